// ----- rtl/core/sacf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_pkg: shared types for the set-associative write-back cache
// Beat structs, action codes and sequencer states.
// ----------------------------------------------------------------------------
package sacf_pkg;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [13:0] address;
        logic [7:0]  write_byte;
    } sacf_in_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] memory_byte;
        logic [7:0] cache_byte;
    } sacf_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT_RD,
        ST_EVICT_WR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_WRITE,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_RESULT
    } sacf_state_t;

endpackage

// ----- rtl/core/set_assoc_cache_fifo_writeback_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_writeback_top: set-associative byte cache, FIFO eviction
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one access beat (action, address, write_byte). A write
//   beat gives no result; a read beat gives one m_ beat (hit, memory_byte,
//   cache_byte). One access is in flight at a time; s_ready drops meanwhile.
//   A read hit passes lookup, a line store and memory read and a wait
//   state before its result beat is registered; s_ready rises again as the
//   beat shows. A write hit is lookup then one line store write. A miss
//   first fills the line (copied from main memory on a read, zeroed on a
//   write); into a full set it first writes back the line in way WAYS-1 and
//   shifts the other WAYS-1 lines up one way. All line traffic moves one byte
//   at a time through the single-port line store and main memory.
//   After reset a clearing pass zeroes the line store and main memory, one
//   entry per cycle (line store in parallel); s_ready stays low until it
//   ends. Tags and valid bits sit in flops. When m_ready is low the result
//   is held in the output register; writes still go on, and the next read
//   waits with its result until it drains.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_writeback_top #(
    parameter int LINE_BYTES = 16,
    parameter int WAYS       = 4,
    parameter int SETS       = 16,
    parameter int MEM_BYTES  = 16384
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sacf_pkg::sacf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sacf_pkg::sacf_out_t m_data
);
    import sacf_pkg::*;

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int MEM_W  = $clog2(MEM_BYTES);
    localparam int LINES  = SETS * WAYS;
    localparam int LINE_W = $clog2(LINES);
    localparam int STORE_W = $clog2(LINES * LINE_BYTES);
    localparam int TAG_W  = (MEM_W - OFF_W - $clog2(SETS) > 0) ?
                            MEM_W - OFF_W - $clog2(SETS) : 1;
    localparam int CNT_W  = OFF_W + 1;

    sacf_state_t state_reg, state_next;

    logic [MEM_W-1:0]  addr_reg, addr_next;
    logic              act_reg, act_next;
    logic [7:0]        wbyte_reg, wbyte_next;
    logic              hit_reg, hit_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic [WAY_W-1:0]  shw_reg, shw_next;      // destination way during shift
    logic [TAG_W-1:0]  evtag_reg, evtag_next;  // tag of the line being evicted
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MEM_W:0]    clr_reg, clr_next;
    logic [7:0]        memb_reg, memb_next;
    logic [7:0]        hold_reg, hold_next;
    logic              m_valid_reg, m_valid_next;
    sacf_out_t         m_data_reg, m_data_next;

    // One entry per set, all ways side by side
    logic [WAYS-1:0][TAG_W-1:0] tag_reg [SETS];
    logic [WAYS-1:0]            vld_reg [SETS];

    // Address split; MEM_BYTES is a power of two so the modulo is a mask
    logic [OFF_W-1:0]  offset;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic [MEM_W-1:0]  s_addr;

    assign s_addr = s_data.address[MEM_W-1:0];
    assign offset = addr_reg[OFF_W-1:0];
    assign tag    = TAG_W'(addr_reg >> (OFF_W + $clog2(SETS)));
    generate
        if (SETS > 1) begin : g_set
            assign set_idx = addr_reg[OFF_W +: SET_W];
        end else begin : g_noset
            assign set_idx = '0;
        end
    endgenerate

    function automatic logic [LINE_W-1:0] line_of(logic [SET_W-1:0] s,
                                                  logic [WAY_W-1:0] w);
        return LINE_W'(s * WAYS + w);
    endfunction

    // Hit search and first invalid way over the set (WAYS compares)
    logic             lk_hit, lk_free;
    logic [WAY_W-1:0] lk_way, lk_fway;
    always_comb begin
        lk_hit  = 1'b0;
        lk_way  = '0;
        lk_free = 1'b0;
        lk_fway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld_reg[set_idx][WAY_W'(w)] &&
                tag_reg[set_idx][WAY_W'(w)] == tag) begin
                lk_hit = 1'b1;
                lk_way = WAY_W'(w);
            end
            if (!vld_reg[set_idx][WAY_W'(w)]) begin
                lk_free = 1'b1;
                lk_fway = WAY_W'(w);
            end
        end
    end

    // Memory ports
    logic               st_we, mm_we;
    logic [STORE_W-1:0] st_addr;
    logic [MEM_W-1:0]   mm_addr;
    logic [7:0]         st_wdata, mm_wdata, st_rdata, mm_rdata;

    sacf_ram #(.WIDTH(8), .DEPTH(LINES * LINE_BYTES)) u_store (
        .aclk(aclk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
    );
    sacf_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk(aclk), .we(mm_we), .addr(mm_addr), .wdata(mm_wdata), .rdata(mm_rdata)
    );

    logic [OFF_W-1:0] byte_i;
    logic             last_byte;
    logic [MEM_W-1:0] evict_base, line_base;
    assign byte_i     = cnt_reg[OFF_W-1:0];
    assign last_byte  = (cnt_reg == CNT_W'(LINE_BYTES - 1));
    assign evict_base = (MEM_W'(evtag_reg) << (OFF_W + $clog2(SETS))) |
                        (MEM_W'(set_idx) << OFF_W);
    assign line_base  = {addr_reg[MEM_W-1:OFF_W], {OFF_W{1'b0}}};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_reg == (MEM_W+1)'(MEM_BYTES - 1)) state_next = ST_IDLE;
            ST_IDLE:      if (s_valid) state_next = ST_LOOKUP;
            ST_LOOKUP: begin
                if (lk_hit) state_next = act_reg ? ST_WRITE : ST_READ_RD;
                else if (lk_free) state_next = act_reg ? ST_FILL_WR : ST_FILL_RD;
                else state_next = ST_EVICT_RD;
            end
            ST_EVICT_RD:  state_next = ST_EVICT_WR;
            ST_EVICT_WR:  if (last_byte) state_next = ST_SHIFT_RD;
                          else state_next = ST_EVICT_RD;
            ST_SHIFT_RD:  state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: begin
                if (!last_byte) state_next = ST_SHIFT_RD;
                else if (shw_reg != WAY_W'(1)) state_next = ST_SHIFT_RD;
                else state_next = act_reg ? ST_FILL_WR : ST_FILL_RD;
            end
            ST_FILL_RD:   state_next = ST_FILL_WR;
            ST_FILL_WR: begin
                if (last_byte) state_next = act_reg ? ST_WRITE : ST_READ_RD;
                else state_next = act_reg ? ST_FILL_WR : ST_FILL_RD;
            end
            ST_WRITE:     state_next = ST_IDLE;
            ST_READ_RD:   state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_RESULT;
            ST_RESULT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        addr_next    = addr_reg;
        act_next     = act_reg;
        wbyte_next   = wbyte_reg;
        hit_next     = hit_reg;
        way_next     = way_reg;
        shw_next     = shw_reg;
        evtag_next   = evtag_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        memb_next    = memb_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        st_we        = 1'b0;
        mm_we        = 1'b0;
        st_addr      = '0;
        mm_addr      = '0;
        st_wdata     = '0;
        mm_wdata     = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                mm_we    = 1'b1;
                mm_addr  = clr_reg[MEM_W-1:0];
                st_we    = (clr_reg < (MEM_W+1)'(LINES * LINE_BYTES));
                st_addr  = STORE_W'(clr_reg);
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                addr_next  = s_addr;
                act_next   = s_data.action;
                wbyte_next = s_data.write_byte;
                cnt_next   = '0;
            end
            ST_LOOKUP: begin
                hit_next   = lk_hit;
                way_next   = lk_hit ? lk_way : (lk_free ? lk_fway : '0);
                shw_next   = WAY_W'(WAYS - 1);
                evtag_next = tag_reg[set_idx][WAY_W'(WAYS - 1)];
                cnt_next   = '0;
            end
            ST_EVICT_RD: begin
                st_addr = {line_of(set_idx, WAY_W'(WAYS - 1)), byte_i};
            end
            ST_EVICT_WR: begin
                mm_we    = 1'b1;
                mm_addr  = evict_base + MEM_W'(byte_i);
                mm_wdata = st_rdata;
                cnt_next = last_byte ? '0 : cnt_reg + 1'b1;
            end
            ST_SHIFT_RD: begin
                st_addr = {line_of(set_idx, shw_reg - 1'b1), byte_i};
            end
            ST_SHIFT_WR: begin
                st_we    = 1'b1;
                st_addr  = {line_of(set_idx, shw_reg), byte_i};
                st_wdata = st_rdata;
                cnt_next = last_byte ? '0 : cnt_reg + 1'b1;
                if (last_byte) shw_next = shw_reg - 1'b1;
            end
            ST_FILL_RD: begin
                mm_addr = line_base + MEM_W'(byte_i);
            end
            ST_FILL_WR: begin
                st_we    = 1'b1;
                st_addr  = {line_of(set_idx, way_reg), byte_i};
                st_wdata = act_reg ? 8'h00 : mm_rdata;
                cnt_next = last_byte ? '0 : cnt_reg + 1'b1;
            end
            ST_WRITE: begin
                st_we    = 1'b1;
                st_addr  = {line_of(set_idx, way_reg), offset};
                st_wdata = wbyte_reg;
            end
            ST_READ_RD: begin
                st_addr = {line_of(set_idx, way_reg), offset};
                mm_addr = addr_reg;
            end
            ST_READ_WAIT: begin
                hold_next = st_rdata;
                memb_next = mm_rdata;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.hit         = hit_reg;
                    m_data_next.memory_byte = memb_reg;
                    m_data_next.cache_byte  = hold_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Tag and valid update at allocation
    logic alloc_now;
    assign alloc_now = (state_reg == ST_LOOKUP) && !lk_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SETS; i++) vld_reg[i] <= '0;
        end else if (alloc_now) begin
            if (lk_free) begin
                vld_reg[set_idx][lk_fway] <= 1'b1;
                tag_reg[set_idx][lk_fway] <= tag;
            end else begin
                tag_reg[set_idx] <= {tag_reg[set_idx][WAYS-2:0], tag};
            end
        end
    end

    // Sequencer and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        addr_reg   <= addr_next;
        act_reg    <= act_next;
        wbyte_reg  <= wbyte_next;
        hit_reg    <= hit_next;
        way_reg    <= way_next;
        shw_reg    <= shw_next;
        evtag_reg  <= evtag_next;
        memb_reg   <= memb_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // No access is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("access accepted during clear");
    // A write never produces a result beat
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESULT |-> !act_reg)
        else $error("result for write access");
    // A lookup that hits is never followed by an eviction
    a_hit_no_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP && lk_hit) |=> state_reg != ST_EVICT_RD)
        else $error("eviction on hit");
`endif
endmodule

// ----- rtl/core/sacf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_ram: generic single-port RAM
// One access per cycle; read data is registered and a write returns the old word.
// ----------------------------------------------------------------------------
module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
